// File: design/fcp_pkg.sv
package fcp_pkg;

   localparam int unsigned AddrWidth = 4;

   localparam logic [31:0] APPLICATION_BASE_RESET = 32'h0800_1000;
   localparam logic [31:0] LOADER_BASE_RESET      = 32'h0800_0000;
   localparam logic [31:0] WINDOW_BYTES_RESET     = 32'h0001_0000;

   typedef enum logic [2:0] {
      VERDICT_ACCEPTED       = 3'd0,
      VERDICT_NO_KEYWORD     = 3'd1,
      VERDICT_BAD_ADDRESS    = 3'd2,
      VERDICT_BAD_SIZE       = 3'd3,
      VERDICT_RANGE_REJECTED = 3'd4
   } verdict_type;

   typedef enum logic [1:0] {
      REG_APPLICATION_BASE = 2'd0,
      REG_LOADER_BASE      = 2'd1,
      REG_WINDOW_BYTES     = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [31:0] application_base;
      logic [31:0] loader_base;
      logic [31:0] window_bytes;
   } config_type;

   // finished command handed to the range stage; check marks one still to be range-checked
   typedef struct packed {
      logic        check;
      verdict_type kind;
      logic [31:0] start_address;
      logic [31:0] image_size;
   } outcome_type;

endpackage

// File: design/flash_command_parser.sv
// Parses a "FLASH <address> <size>" text command one character per transfer on the req
// channel and returns one verdict transfer on the rsp channel for the character marked
// end_of_command. A character is taken every clock; the input stalls only when a finished
// verdict is waiting behind a stalled rsp channel. After the last character is taken, the parsed
// command is registered, then the range check against the base and window registers is registered;
// a stalled rsp channel can hold the parsed command in between. Registers sit on the APB-style
// port at 0x0 (application base), 0x4 (loader base) and 0x8 (window bytes), zero wait state.
// The user must write them only while no command is in flight; the block does not enforce this.
module flash_command_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_char_byte,
   input  logic                           req_end_of_command,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [2:0]                     rsp_verdict,
   output logic [31:0]                    rsp_start_address,
   output logic [31:0]                    rsp_image_size,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [fcp_pkg::AddrWidth-1:0]  paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);
   import fcp_pkg::*;

   config_type  cfg;
   logic        outcome_valid;
   logic        outcome_take;
   outcome_type outcome;

   fcp_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fcp_parser u_parser (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_byte      (req_char_byte),
      .req_end_of_command (req_end_of_command),
      .outcome_take       (outcome_take),
      .outcome_valid      (outcome_valid),
      .outcome            (outcome)
   );

   fcp_range u_range (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .outcome_valid     (outcome_valid),
      .outcome           (outcome),
      .outcome_take      (outcome_take),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_verdict       (rsp_verdict),
      .rsp_start_address (rsp_start_address),
      .rsp_image_size    (rsp_image_size)
   );

endmodule

// File: design/fcp_regs.sv
module fcp_regs (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [fcp_pkg::AddrWidth-1:0]  paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready,
   output fcp_pkg::config_type            cfg
);
   import fcp_pkg::*;

   config_type    cfg_ff;
   config_type    cfg_in;
   reg_index_type index;
   logic          write_en;

   assign index    = reg_index_type'(paddr[3:2]);
   assign write_en = psel & penable & pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_APPLICATION_BASE: cfg_in.application_base = pwdata;
            REG_LOADER_BASE:      cfg_in.loader_base      = pwdata;
            REG_WINDOW_BYTES:     cfg_in.window_bytes     = pwdata;
            default:              cfg_in                  = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_APPLICATION_BASE: prdata = cfg_ff.application_base;
         REG_LOADER_BASE:      prdata = cfg_ff.loader_base;
         REG_WINDOW_BYTES:     prdata = cfg_ff.window_bytes;
         default:              prdata = 32'h0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.application_base <= APPLICATION_BASE_RESET;
         cfg_ff.loader_base      <= LOADER_BASE_RESET;
         cfg_ff.window_bytes     <= WINDOW_BYTES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: design/fcp_parser.sv
module fcp_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_char_byte,
   input  logic                  req_end_of_command,
   input  logic                  outcome_take,
   output logic                  outcome_valid,
   output fcp_pkg::outcome_type  outcome
);
   import fcp_pkg::*;

   typedef enum logic [2:0] {
      PH_LEAD = 3'd0,
      PH_KEY  = 3'd1,
      PH_GAP1 = 3'd2,
      PH_NUM1 = 3'd3,
      PH_GAP2 = 3'd4,
      PH_NUM2 = 3'd5,
      PH_DONE = 3'd6
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [2:0]  key_pos;
      logic [31:0] number;
      logic        hex;
      logic [1:0]  digits;
      logic [31:0] saved;
      verdict_type kind;
      logic        check;
   } parse_type;

   typedef struct packed {
      logic      again;
      parse_type st;
   } pass_type;

   localparam int unsigned MaxPasses = 4;

   localparam logic [7:0] CharNul   = 8'h00;
   localparam logic [7:0] CharTab   = 8'h09;
   localparam logic [7:0] CharLf    = 8'h0A;
   localparam logic [7:0] CharCr    = 8'h0D;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharUpA   = 8'h41;
   localparam logic [7:0] CharUpF   = 8'h46;
   localparam logic [7:0] CharLowA  = 8'h61;
   localparam logic [7:0] CharLowF  = 8'h66;
   localparam logic [7:0] CharUpX   = 8'h58;
   localparam logic [7:0] CharLowX  = 8'h78;

   localparam parse_type ParseReset = '{
      phase:   PH_LEAD,
      key_pos: 3'd0,
      number:  32'h0,
      hex:     1'b0,
      digits:  2'd0,
      saved:   32'h0,
      kind:    VERDICT_ACCEPTED,
      check:   1'b0
   };

   function automatic logic [7:0] key_char(input logic [2:0] pos);
      logic [7:0] ch;
      unique case (pos)
         3'd0:    ch = 8'h46;   // F
         3'd1:    ch = 8'h4C;   // L
         3'd2:    ch = 8'h41;   // A
         3'd3:    ch = 8'h53;   // S
         3'd4:    ch = 8'h48;   // H
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // one pass over the current phase; again asks for the same character once more
   function automatic pass_type do_pass(input parse_type s, input logic [7:0] c,
                                        input logic [31:0] grown);
      pass_type    r;
      verdict_type fail;
      logic        blank;
      logic        term;
      logic        dec_digit;
      logic        hex_letter;
      logic        handled;
      r.st       = s;
      r.again    = 1'b0;
      blank      = (c == CharSpace) || (c == CharTab);
      term       = blank || (c == CharNul) || (c == CharCr) || (c == CharLf);
      dec_digit  = (c >= CharZero) && (c <= CharNine);
      hex_letter = ((c >= CharLowA) && (c <= CharLowF)) || ((c >= CharUpA) && (c <= CharUpF));
      fail       = (s.phase == PH_NUM1) ? VERDICT_BAD_ADDRESS : VERDICT_BAD_SIZE;
      handled    = 1'b0;
      unique case (s.phase)
         PH_LEAD: begin
            if (!blank) begin
               r.st.phase = PH_KEY;
               r.again    = 1'b1;
            end
         end
         PH_KEY: begin
            if ((s.key_pos <= 3'd4) && (c == key_char(s.key_pos))) begin
               r.st.key_pos = s.key_pos + 3'd1;
               if (s.key_pos == 3'd4) r.st.phase = PH_GAP1;
            end else begin
               r.st.kind  = VERDICT_NO_KEYWORD;
               r.st.phase = PH_DONE;
            end
         end
         PH_GAP1, PH_GAP2: begin
            if (!blank) begin
               r.st.phase  = (s.phase == PH_GAP1) ? PH_NUM1 : PH_NUM2;
               r.st.digits = 2'd0;
               r.st.hex    = 1'b0;
               r.st.number = 32'h0;
               r.again     = 1'b1;
            end
         end
         PH_NUM1, PH_NUM2: begin
            priority if (s.digits == 2'd0) begin
               if ((c == CharNul) || blank) begin
                  r.st.kind  = fail;
                  r.st.phase = PH_DONE;
                  handled    = 1'b1;
               end else if (c == CharZero) begin
                  r.st.number = 32'h0;
                  r.st.digits = 2'd1;
                  handled     = 1'b1;
               end
            end else if (s.digits == 2'd1) begin
               if ((c == CharLowX) || (c == CharUpX)) begin
                  r.st.hex    = 1'b1;
                  r.st.digits = 2'd2;
                  handled     = 1'b1;
               end
            end else if (s.digits == 2'd2) begin
               // prefix with nothing behind it
               if ((c == CharNul) || blank) begin
                  r.st.kind  = fail;
                  r.st.phase = PH_DONE;
                  handled    = 1'b1;
               end
            end else begin
               handled = 1'b0;
            end
            if (!handled) begin
               r.st.digits = 2'd3;
               if (term) begin
                  if (s.phase == PH_NUM1) begin
                     r.st.saved  = s.number;
                     r.st.number = 32'h0;
                     r.st.hex    = 1'b0;
                     r.st.digits = 2'd0;
                     r.st.phase  = PH_GAP2;
                     r.again     = 1'b1;
                  end else begin
                     // range check happens in the next stage
                     r.st.kind  = VERDICT_ACCEPTED;
                     r.st.check = 1'b1;
                     r.st.phase = PH_DONE;
                  end
               end else if (dec_digit || (hex_letter && s.hex)) begin
                  r.st.number = grown;
               end else begin
                  r.st.kind  = fail;
                  r.st.phase = PH_DONE;
               end
            end
         end
         default: r.again = 1'b0;
      endcase
      return r;
   endfunction

   function automatic parse_type feed(input parse_type s, input logic [7:0] c,
                                      input logic [31:0] grown);
      parse_type cur;
      pass_type  r;
      logic      go;
      cur = s;
      go  = 1'b1;
      for (int i = 0; i < MaxPasses; i++) begin
         if (go) begin
            r   = do_pass(cur, c, grown);
            cur = r.st;
            go  = r.again;
         end
      end
      return cur;
   endfunction

   parse_type   state_ff;
   parse_type   state_in;
   parse_type   after_char;
   parse_type   after_end;
   logic        outcome_valid_ff;
   logic        outcome_valid_in;
   outcome_type outcome_ff;
   outcome_type outcome_in;
   outcome_type outcome_new;
   logic        accept;
   logic        accept_last;
   logic [3:0]  digit;
   logic [31:0] grown;

   assign req_stall     = outcome_valid_ff & ~outcome_take;
   assign accept        = req_valid & ~req_stall;
   assign accept_last   = accept & req_end_of_command;
   assign outcome_valid = outcome_valid_ff;
   assign outcome       = outcome_ff;

   always_comb begin
      // a digit always lands on the number held in state_ff, so one multiply-add serves
      digit = (req_char_byte <= CharNine) ? req_char_byte[3:0] : req_char_byte[3:0] + 4'd9;
      grown = (state_ff.hex ? {state_ff.number[27:0], 4'h0}
                            : {state_ff.number[28:0], 3'b000} + {state_ff.number[30:0], 1'b0})
              + {28'h0, digit};

      after_char = feed(state_ff, req_char_byte, grown);
      // the end of a command behaves as a trailing zero byte
      after_end  = feed(after_char, CharNul, grown);

      outcome_new.check         = after_end.check;
      outcome_new.kind          = after_end.kind;
      outcome_new.start_address = (!after_end.check &&
                                   ((after_end.kind == VERDICT_NO_KEYWORD) ||
                                    (after_end.kind == VERDICT_BAD_ADDRESS)))
                                  ? 32'h0 : after_end.saved;
      outcome_new.image_size    = after_end.check ? after_end.number : 32'h0;

      if (accept) begin
         state_in = req_end_of_command ? ParseReset : after_char;
      end else begin
         state_in = state_ff;
      end
      outcome_in       = accept_last ? outcome_new : outcome_ff;
      outcome_valid_in = (outcome_valid_ff & ~outcome_take) | accept_last;
   end

   always_ff @(posedge clock) begin
      outcome_ff <= outcome_in;
      if (reset) begin
         state_ff         <= ParseReset;
         outcome_valid_ff <= 1'b0;
      end else begin
         state_ff         <= state_in;
         outcome_valid_ff <= outcome_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_restart_after_command: assert property (@(posedge clock) disable iff (reset)
      accept_last |=> (state_ff.phase == PH_LEAD) && !state_ff.check)
      else $error("parser did not restart after the last character");

   a_outcome_held: assert property (@(posedge clock) disable iff (reset)
      outcome_valid_ff && !outcome_take |=> outcome_valid_ff && $stable(outcome_ff))
      else $error("pending outcome lost or changed");

   a_key_position: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_KEY |-> state_ff.key_pos <= 3'd4)
      else $error("keyword position out of range");
`endif

endmodule

// File: design/fcp_range.sv
module fcp_range (
   input  logic                  clock,
   input  logic                  reset,
   input  fcp_pkg::config_type   cfg,
   input  logic                  outcome_valid,
   input  fcp_pkg::outcome_type  outcome,
   output logic                  outcome_take,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_verdict,
   output logic [31:0]           rsp_start_address,
   output logic [31:0]           rsp_image_size
);
   import fcp_pkg::*;

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   verdict_type rsp_verdict_ff;
   verdict_type rsp_verdict_in;
   logic [31:0] rsp_start_address_ff;
   logic [31:0] rsp_start_address_in;
   logic [31:0] rsp_image_size_ff;
   logic [31:0] rsp_image_size_in;

   logic [31:0] offset;
   logic [31:0] range_end;
   logic [32:0] top_sum;
   logic        reject;
   verdict_type verdict;

   assign outcome_take = outcome_valid & (~rsp_valid_ff | ~rsp_stall);

   always_comb begin
      offset    = outcome.start_address - cfg.loader_base;
      range_end = offset + outcome.image_size;
      top_sum   = {1'b0, outcome.start_address} + {1'b0, outcome.image_size};
      reject    = (outcome.image_size == 32'h0)
                | (outcome.start_address[1:0] != 2'b00)
                | (outcome.start_address < cfg.application_base)
                | (outcome.start_address < cfg.loader_base)
                | (range_end > cfg.window_bytes)
                | top_sum[32];
      if (outcome.check) begin
         verdict = reject ? VERDICT_RANGE_REJECTED : VERDICT_ACCEPTED;
      end else begin
         verdict = outcome.kind;
      end

      rsp_valid_in = (rsp_valid_ff & rsp_stall) | outcome_take;
      if (outcome_take) begin
         rsp_verdict_in       = verdict;
         rsp_start_address_in = outcome.start_address;
         rsp_image_size_in    = outcome.image_size;
      end else begin
         rsp_verdict_in       = rsp_verdict_ff;
         rsp_start_address_in = rsp_start_address_ff;
         rsp_image_size_in    = rsp_image_size_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_verdict_ff       <= rsp_verdict_in;
      rsp_start_address_ff <= rsp_start_address_in;
      rsp_image_size_ff    <= rsp_image_size_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_verdict       = rsp_verdict_ff;
   assign rsp_start_address = rsp_start_address_ff;
   assign rsp_image_size    = rsp_image_size_ff;

`ifndef ASSERT_OFF
   a_accepted_range_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_verdict_ff == VERDICT_ACCEPTED)
      |-> (rsp_image_size_ff != 32'h0) && (rsp_start_address_ff[1:0] == 2'b00))
      else $error("accepted range with zero size or misaligned start");

   a_no_keyword_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ((rsp_verdict_ff == VERDICT_NO_KEYWORD) ||
                       (rsp_verdict_ff == VERDICT_BAD_ADDRESS))
      |-> (rsp_start_address_ff == 32'h0) && (rsp_image_size_ff == 32'h0))
      else $error("address or size reported for a command without an address");

   a_bad_size_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_verdict_ff == VERDICT_BAD_SIZE) |-> rsp_image_size_ff == 32'h0)
      else $error("size reported for a command with a bad size");
`endif

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

import fcp_pkg::*;

localparam logic [7:0] CH_NUL = 8'h00;
localparam logic [7:0] CH_TAB = 8'h09;
localparam logic [7:0] CH_LF = 8'h0A;
localparam logic [7:0] CH_CR = 8'h0D;
localparam logic [7:0] CH_SPACE = 8'h20;
localparam logic [39:0] KEYWORD = "FLASH";

localparam logic [1:0] NO_DIGITS = 2'd0;
localparam logic [1:0] LONE_ZERO = 2'd1;
localparam logic [1:0] AFTER_PREFIX = 2'd2;
localparam logic [1:0] IN_DIGITS = 2'd3;

typedef enum logic [3:0] {
   SKIP_LEAD = 4'd0,
   MATCH_KEY = 4'd1,
   GAP_ADDR  = 4'd2,
   READ_ADDR = 4'd3,
   GAP_SIZE  = 4'd4,
   READ_SIZE = 4'd5,
   DECIDED   = 4'd6
} parse_phase_type;

typedef struct packed {
   verdict_type verdict;
   logic [31:0] start_address;
   logic [31:0] image_size;
} flash_verdict_type;

class flash_scoreboard;
   logic [31:0] application_base;
   logic [31:0] loader_base;
   logic [31:0] window_bytes;
   parse_phase_type phase;
   logic [2:0] key_pos;
   logic [31:0] value;
   logic hex;
   logic [1:0] digits;
   logic [31:0] saved_address;
   verdict_type kind;
   flash_verdict_type pending_verdicts[$];
   int mismatches;

   function new();
      application_base = APPLICATION_BASE_RESET;
      loader_base = LOADER_BASE_RESET;
      window_bytes = WINDOW_BYTES_RESET;
      mismatches = 0;
      clear_parse();
   endfunction

   function void clear_parse();
      phase = SKIP_LEAD;
      key_pos = 3'd0;
      value = 32'd0;
      hex = 1'b0;
      digits = NO_DIGITS;
      saved_address = 32'd0;
      kind = VERDICT_ACCEPTED;
   endfunction

   function void write_register(reg_index_type idx, logic [31:0] v);
      case (idx)
         REG_APPLICATION_BASE: application_base = v;
         REG_LOADER_BASE: loader_base = v;
         REG_WINDOW_BYTES: window_bytes = v;
         default: ;
      endcase
   endfunction

   function bit blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB;
   endfunction

   function bit terminator(logic [7:0] c);
      return c == CH_NUL || blank(c) || c == CH_CR || c == CH_LF;
   endfunction

   function void decide(verdict_type v);
      kind = v;
      phase = DECIDED;
   endfunction

   function verdict_type range_verdict(logic [31:0] start, logic [31:0] size);
      logic [31:0] span;
      logic [31:0] stop;
      span = start - loader_base + size;
      stop = start + size;
      if (size == 32'd0 || start[1:0] != 2'b00 || start < application_base ||
          start < loader_base || span > window_bytes || stop < start)
         return VERDICT_RANGE_REJECTED;
      return VERDICT_ACCEPTED;
   endfunction

   // returns 1 when the terminator has to be looked at again
   function bit close_number();
      if (phase == READ_ADDR) begin
         saved_address = value;
         value = 32'd0;
         hex = 1'b0;
         digits = NO_DIGITS;
         phase = GAP_SIZE;
         return 1'b1;
      end
      decide(range_verdict(saved_address, value));
      return 1'b0;
   endfunction

   function bit number_char(logic [7:0] c);
      verdict_type fail;
      logic [4:0] radix;
      logic [4:0] d;
      fail = (phase == READ_ADDR) ? VERDICT_BAD_ADDRESS : VERDICT_BAD_SIZE;
      radix = hex ? 5'd16 : 5'd10;
      if (digits == NO_DIGITS) begin
         if (c == CH_NUL || blank(c)) begin
            decide(fail);
            return 1'b0;
         end
         if (c == "0") begin
            value = 32'd0;
            digits = LONE_ZERO;
            return 1'b0;
         end
      end else if (digits == LONE_ZERO) begin
         if (c == "x" || c == "X") begin
            hex = 1'b1;
            radix = 5'd16;
            digits = AFTER_PREFIX;
            return 1'b0;
         end
      end else if (digits == AFTER_PREFIX) begin
         if (c == CH_NUL || blank(c)) begin
            decide(fail);
            return 1'b0;
         end
      end
      digits = IN_DIGITS;
      if (terminator(c)) return close_number();
      if (c >= "0" && c <= "9") d = 5'(c - "0");
      else if (c >= "a" && c <= "f") d = 5'(c - "a" + 8'd10);
      else if (c >= "A" && c <= "F") d = 5'(c - "A" + 8'd10);
      else begin
         decide(fail);
         return 1'b0;
      end
      if (d >= radix) begin
         decide(fail);
         return 1'b0;
      end
      value = value * 32'(radix) + 32'(d);
      return 1'b0;
   endfunction

   function void feed(logic [7:0] c);
      bit again;
      again = 1'b1;
      while (again) begin
         again = 1'b0;
         case (phase)
            SKIP_LEAD: begin
               if (!blank(c)) begin
                  phase = MATCH_KEY;
                  again = 1'b1;
               end
            end
            MATCH_KEY: begin
               if (key_pos < 3'd5 && c == KEYWORD[8 * (4 - key_pos) +: 8]) begin
                  key_pos = key_pos + 3'd1;
                  if (key_pos == 3'd5) phase = GAP_ADDR;
               end else begin
                  decide(VERDICT_NO_KEYWORD);
               end
            end
            GAP_ADDR, GAP_SIZE: begin
               if (!blank(c)) begin
                  phase = (phase == GAP_ADDR) ? READ_ADDR : READ_SIZE;
                  digits = NO_DIGITS;
                  hex = 1'b0;
                  value = 32'd0;
                  again = 1'b1;
               end
            end
            READ_ADDR, READ_SIZE: again = number_char(c);
            default: ;
         endcase
      end
   endfunction

   function void note_transfer(logic [7:0] c, logic last);
      flash_verdict_type r;
      feed(c);
      if (!last) return;
      // end of command behaves like a trailing zero byte
      feed(CH_NUL);
      r.verdict = kind;
      r.start_address = (kind == VERDICT_NO_KEYWORD || kind == VERDICT_BAD_ADDRESS) ?
                        32'd0 : saved_address;
      r.image_size = (kind == VERDICT_ACCEPTED || kind == VERDICT_RANGE_REJECTED) ?
                     value : 32'd0;
      pending_verdicts.push_back(r);
      clear_parse();
   endfunction

   function void check_transfer(logic [2:0] v, logic [31:0] a, logic [31:0] s);
      flash_verdict_type want;
      if (pending_verdicts.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("verdict transfer with none pending: verdict %0d start %h size %h",
                     v, a, s);
         return;
      end
      want = pending_verdicts.pop_front();
      if (v !== want.verdict || a !== want.start_address || s !== want.image_size) begin
         mismatches++;
         if (mismatches <= 10)
            $display("bad verdict: verdict %0d/%0d start %h/%h size %h/%h (expected/actual)",
                     want.verdict, v, want.start_address, a, want.image_size, s);
      end
   endfunction

   function int outstanding();
      return pending_verdicts.size();
   endfunction
endclass

module tb;

   localparam int PHASE_CHARS = 210;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [7:0] req_char_byte;
   logic req_end_of_command;
   logic rsp_valid;
   logic rsp_stall;
   logic [2:0] rsp_verdict;
   logic [31:0] rsp_start_address;
   logic [31:0] rsp_image_size;
   logic psel;
   logic penable;
   logic pwrite;
   logic [AddrWidth-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   flash_scoreboard board;
   logic [7:0] command_text[$];
   bit tx_idle;
   bit rx_idle;
   int long_hold;

   flash_command_parser uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_char_byte(req_char_byte),
      .req_end_of_command(req_end_of_command),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_verdict(rsp_verdict),
      .rsp_start_address(rsp_start_address),
      .rsp_image_size(rsp_image_size),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #1 clock = ~clock;

   function automatic void add_char(logic [7:0] c);
      command_text.push_back(c);
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) add_char(s[i]);
   endfunction

   function automatic void add_blanks(int lo, int hi);
      repeat ($urandom_range(lo, hi)) add_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
   endfunction

   function automatic void add_junk(int n);
      repeat (n) add_char(8'($urandom_range(0, 255)));
   endfunction

   function automatic logic [7:0] pick_bad_char();
      case ($urandom_range(0, 5))
         0: return "g";
         1: return "Z";
         2: return ".";
         3: return "-";
         4: return 8'hFF;
         default: return 8'($urandom_range(8'h80, 8'hFE));
      endcase
   endfunction

   function automatic void add_keyword(bit corrupt);
      int bad_pos;
      bad_pos = corrupt ? $urandom_range(0, 4) : 5;
      for (int k = 0; k < 5; k++) begin
         if (k != bad_pos) add_char(KEYWORD[8 * (4 - k) +: 8]);
         else if ($urandom_range(0, 1)) add_char(KEYWORD[8 * (4 - k) +: 8] + 8'd32);
         else add_char(8'($urandom_range(0, 255)));
      end
   endfunction

   function automatic void add_number(logic [31:0] v);
      string digits_text;
      string hex_set;
      logic [7:0] ch;
      int style;
      hex_set = "0123456789abcdefABCDEF";
      style = $urandom_range(0, 9);
      if (style < 4) begin
         if ($urandom_range(0, 7) == 0) add_char("0");
         digits_text = $sformatf("%0d", v);
      end else if (style < 8) begin
         add_char("0");
         add_char($urandom_range(0, 1) ? "x" : "X");
         if ($urandom_range(0, 7) == 0) add_char("0");
         digits_text = $sformatf("%0h", v);
      end else begin
         // too many digits, value may wrap
         digits_text = "";
         if (style == 9) begin
            add_char("0");
            add_char("x");
            repeat ($urandom_range(9, 12)) add_char(hex_set[$urandom_range(0, 21)]);
         end else begin
            repeat ($urandom_range(11, 15)) add_char(hex_set[$urandom_range(0, 9)]);
         end
      end
      for (int i = 0; i < digits_text.len(); i++) begin
         ch = digits_text[i];
         if (ch >= "a" && ch <= "f" && $urandom_range(0, 1)) ch = ch - 8'd32;
         add_char(ch);
      end
   endfunction

   function automatic logic [31:0] pick_start();
      logic [31:0] lo;
      lo = (board.application_base > board.loader_base) ?
           board.application_base : board.loader_base;
      lo = (lo + 32'd3) & ~32'd3;
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'hFFFF_FFFC : 32'd0;
         2: return lo + 32'd1 + 32'd4 * $urandom_range(0, 64);
         3: return lo - 32'd4;
         default: return lo + 32'd4 * $urandom_range(0, 1023);
      endcase
   endfunction

   function automatic logic [31:0] pick_size(logic [31:0] start);
      logic [31:0] room;
      room = board.loader_base + board.window_bytes - start;
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return $urandom;
         2: return room;
         3: return room + 32'd1;
         default: return $urandom_range(1, 4096);
      endcase
   endfunction

   function automatic void add_command_core(logic [31:0] start, logic [31:0] size);
      add_blanks(0, 2);
      add_keyword(1'b0);
      add_blanks($urandom_range(0, 9) == 0 ? 0 : 1, 3);
      add_number(start);
      add_blanks(1, 2);
      add_number(size);
   endfunction

   function automatic void build_random_command();
      logic [31:0] start;
      logic [31:0] size;
      int style;
      start = pick_start();
      size = pick_size(start);
      style = $urandom_range(0, 99);
      if (style < 65) begin
         add_command_core(start, size);
         case ($urandom_range(0, 5))
            3: add_char(CH_CR);
            4: add_char(CH_LF);
            5: begin
               add_char(CH_SPACE);
               add_junk($urandom_range(1, 4));
            end
            default: ;
         endcase
      end else if (style < 70) begin
         add_blanks(0, 2);
         add_keyword(1'b1);
         add_blanks(1, 2);
         add_number(start);
         add_blanks(1, 2);
         add_number(size);
      end else if (style < 76) begin
         add_keyword(1'b0);
         add_blanks(1, 2);
         add_number(start);
         add_char(pick_bad_char());
         add_blanks(1, 2);
         add_number(size);
      end else if (style < 82) begin
         add_keyword(1'b0);
         add_blanks(1, 2);
         add_number(start);
         add_blanks(1, 2);
         add_number(size);
         add_char(pick_bad_char());
         add_junk($urandom_range(0, 3));
      end else if (style < 86) begin
         add_command_core(start, size);
         command_text.insert($urandom_range(0, command_text.size() - 1), CH_NUL);
         add_junk($urandom_range(0, 5));
      end else if (style < 90) begin
         add_keyword(1'b0);
         add_blanks(1, 2);
         add_number(start);
         add_char($urandom_range(0, 1) ? CH_CR : CH_LF);
         if ($urandom_range(0, 1)) begin
            add_blanks(1, 2);
            add_number(size);
         end
      end else if (style < 94) begin
         add_keyword(1'b0);
         add_blanks(0, 2);
         case ($urandom_range(0, 5))
            0: ;
            1: add_char(CH_CR);
            2: add_text("0x");
            3: add_text("0X ");
            4: begin
               add_number(start);
               add_blanks(1, 2);
               add_text("0x\n");
            end
            default: begin
               add_text("0x\r");
               add_blanks(0, 2);
               add_number(size);
            end
         endcase
      end else begin
         add_junk($urandom_range(1, 10));
      end
   endfunction

   task automatic send_char(logic [7:0] c, logic last);
      int gap;
      gap = tx_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_char_byte = c;
      req_end_of_command = last;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.note_transfer(c, last);
      @(negedge clock);
   endtask

   task automatic send_command();
      for (int i = 0; i < command_text.size(); i++)
         send_char(command_text[i], i == command_text.size() - 1);
      command_text.delete();
      req_valid = 1'b0;
   endtask

   task automatic send_text(string s);
      add_text(s);
      send_command();
   endtask

   task automatic write_register(reg_index_type idx, logic [31:0] v);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = AddrWidth'(4 * int'(idx));
      pwdata = v;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      board.write_register(idx, v);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   task automatic apply_settings(logic [31:0] app, logic [31:0] ldr, logic [31:0] win);
      write_register(REG_APPLICATION_BASE, app);
      write_register(REG_LOADER_BASE, ldr);
      write_register(REG_WINDOW_BYTES, win);
   endtask

   task automatic wait_for_drain();
      while (board.outstanding() != 0) @(negedge clock);
   endtask

   // result side
   initial begin
      int rx_wait;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rx_wait = rx_idle ? $urandom_range(0, 7) : 0;
         if (long_hold > 0) begin
            rx_wait = long_hold;
            long_hold = 0;
         end
         if (rx_wait > 0) begin
            rsp_stall = 1'b1;
            repeat (rx_wait) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         board.check_transfer(rsp_verdict, rsp_start_address, rsp_image_size);
      end
   end

   initial begin
      #500_000;
      $display("flash_command_parser: mismatch");
      $finish;
   end

   initial begin
      int sent;
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_char_byte = 8'd0;
      req_end_of_command = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = 32'd0;
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      long_hold = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_text("FLASH 0x08001000 0x100");
      send_text(" \tFLASH\t134221824  16\r\n");
      send_text("flash 0x08001000 16");
      send_text("FLASH 0x0800100G 16");
      send_text("FLASH 0X08001000 1z");
      send_text("FLASH 0xFFFFFFFF 4294967295");
      send_text("FLASH 99999999999 0");
      send_text("FLASH 0x08001000\r");
      send_text("FLASH 0x 16");
      send_text("FLASH 0x08001000 \n");
      add_text("FLASH 0x08001000 8");
      add_char(CH_NUL);
      send_text("9x");
      send_text("FLASH 0x08001000 16 junk");
      add_char(8'hFF);
      send_command();
      send_text("FLASH");

      for (int p = 0; p < 7; p++) begin
         if (p > 0) begin
            // registers change only with no command in flight
            wait_for_drain();
            repeat (4) @(negedge clock);
            case (p)
               1: apply_settings(32'd0, 32'd0, 32'd0);
               2: apply_settings('1, '1, '1);
               3: apply_settings(32'd0, 32'd0, '1);
               4: apply_settings($urandom, $urandom, $urandom_range(0, 32'h0010_0000));
               5: apply_settings(32'h0000_1000, 32'h2000_0000, 32'h0010_0000);
               default: apply_settings(APPLICATION_BASE_RESET, LOADER_BASE_RESET,
                                       WINDOW_BYTES_RESET);
            endcase
         end
         tx_idle = !(p == 3 || p == 5);
         rx_idle = !(p == 2 || p == 5);
         // back up the result side so the parser fills and stalls its input
         if (p == 3) long_hold = 400;
         sent = 0;
         while (sent < PHASE_CHARS) begin
            build_random_command();
            sent += command_text.size();
            send_command();
            if ($urandom_range(0, 19) == 0) wait_for_drain();
         end
      end

      req_valid = 1'b0;
      wait_for_drain();
      repeat (10) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("flash_command_parser: match");
      end else begin
         $display("flash_command_parser: mismatch");
      end
      $finish;
   end

endmodule
